FILE: src/bdr_pkg.sv
// ----------------------------------------------------------------------------
// bdr_pkg
// Shared constants and the CORDIC arctangent table for the bicycle
// dead reckoning step.
// ----------------------------------------------------------------------------
package bdr_pkg;

    localparam int ANG_W      = 34;
    localparam int ANG_IDX_W  = 5;
    localparam int MUL_A_W    = 36;
    localparam int MUL_B_W    = 25;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int DIV_Q_W    = 24;

    localparam logic signed [ANG_W-1:0]   K_Q30      = 34'sd652032874;
    localparam logic signed [MUL_A_W-1:0] PI_Q30     = 36'sd3373259426;
    localparam logic signed [MUL_A_W-1:0] INV2PI_Q32 = 36'sd683565276;
    localparam logic signed [14:0]        STEER_LIM  = 15'sd12288;
    localparam logic signed [31:0]        POS_MAX    = 32'sh7fffffff;
    localparam logic signed [31:0]        POS_MIN    = 32'sh80000000;

    localparam logic REQ_STEP    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    localparam logic REG_INV_WHEELBASE = 1'b0;
    localparam logic REG_START_HEADING = 1'b1;

    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [ANG_IDX_W-1:0] i);
        case (i)
            5'd0:    atan_entry = 34'sd843314857;
            5'd1:    atan_entry = 34'sd497837829;
            5'd2:    atan_entry = 34'sd263043836;
            5'd3:    atan_entry = 34'sd133525158;
            5'd4:    atan_entry = 34'sd67021686;
            5'd5:    atan_entry = 34'sd33543515;
            5'd6:    atan_entry = 34'sd16771754;
            5'd7:    atan_entry = 34'sd8388437;
            5'd8:    atan_entry = 34'sd4194282;
            5'd9:    atan_entry = 34'sd2097149;
            default: atan_entry = 34'sd1 <<< (5'd30 - i);
        endcase
    endfunction

endpackage

FILE: src/bdr_cordic.sv
// ----------------------------------------------------------------------------
// bdr_cordic
// Rotation-mode CORDIC, one iteration per cycle, giving cosine and sine
// in Q2.30 of an angle in Q2.30 radians.
// ----------------------------------------------------------------------------
module bdr_cordic
    import bdr_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [ANG_W-1:0] angle,
    output logic                    done,
    output logic signed [ANG_W-1:0] cos_val,
    output logic signed [ANG_W-1:0] sin_val
);

    localparam int CW = $clog2(STEPS);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CW-1:0]           iter_reg;
    logic signed [ANG_W-1:0] x_reg;
    logic signed [ANG_W-1:0] y_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic signed [ANG_W-1:0] shx;
    logic signed [ANG_W-1:0] shy;
    logic signed [ANG_W-1:0] ang_step;

    always_comb
    begin
        shx      = y_reg >>> iter_reg;
        shy      = x_reg >>> iter_reg;
        ang_step = atan_entry(ANG_IDX_W'(iter_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
                x_reg    <= K_Q30;
                y_reg    <= '0;
                z_reg    <= angle;
            end
            else if (busy_reg)
            begin
                if (!z_reg[ANG_W-1])
                begin
                    x_reg <= x_reg - shx;
                    y_reg <= y_reg + shy;
                    z_reg <= z_reg - ang_step;
                end
                else
                begin
                    x_reg <= x_reg + shx;
                    y_reg <= y_reg - shy;
                    z_reg <= z_reg + ang_step;
                end
                if (iter_reg == CW'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    iter_reg <= iter_reg + 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign cos_val = x_reg;
    assign sin_val = y_reg;

endmodule

FILE: src/bicycle_dead_reckoning_step.sv
// ----------------------------------------------------------------------------
// bicycle_dead_reckoning_step
// One Euler step of a kinematic bicycle model per item, using a shared
// CORDIC, a bit-serial divider and one shared multiplier.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    req_type, sample_valid, steer_angle,
//                                             speed, time_step
// out       output     out_valid / out_ready  pos_x, pos_z, heading_angle, saturated
// cfg       input      cfg_wr_en              cfg_index, cfg_wdata
//
// A restart item has its result valid in the cycle after acceptance.
// A step item runs two CORDIC passes of one iteration per cycle, with a
// bit-serial divider and a chain of multiplies on the shared multiplier.
// One item is in work at a time; in_ready is low until the result is taken.
// The result holds on the outputs while out_ready is low.
// Reset restores the pose, held sample and registers to their initial values.
// ----------------------------------------------------------------------------
module bicycle_dead_reckoning_step
    import bdr_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic               sample_valid,
    input  logic signed [14:0] steer_angle,
    input  logic signed [15:0] speed,
    input  logic [15:0]        time_step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_z,
    output logic [15:0]        heading_angle,
    output logic               saturated,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [21:0]        cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_C1_GO, S_C1_WAIT, S_DIV, S_M1, S_M2, S_M3, S_M4A, S_M4B,
        S_HEAD, S_ANG, S_C2_GO, S_C2_WAIT, S_M5, S_M6A, S_M6B, S_ADD, S_OUT
    } state_t;

    state_t                    state_reg;
    logic [21:0]               inv_wb_reg;
    logic [15:0]               start_hd_reg;
    logic signed [31:0]        x_reg;
    logic signed [31:0]        z_reg;
    logic [15:0]               heading_reg;
    logic signed [14:0]        held_steer_reg;
    logic signed [15:0]        held_speed_reg;
    logic [15:0]               dt_reg;
    logic                      sat_reg;
    logic                      axis_reg;
    logic                      neg_reg;
    logic                      sneg_reg;
    logic [4:0]                div_cnt_reg;
    logic [ANG_W-1:0]          rem_reg;
    logic [DIV_Q_W-1:0]        dq_reg;
    logic signed [ANG_W-1:0]   c_reg;
    logic signed [ANG_W-1:0]   s_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  acc_reg;
    logic signed [MUL_B_W-1:0] hold_reg;

    logic                      cor_start;
    logic signed [ANG_W-1:0]   cor_angle;
    logic                      cor_done;
    logic signed [ANG_W-1:0]   cor_cos;
    logic signed [ANG_W-1:0]   cor_sin;

    logic                      mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    logic signed [14:0]        steer_cl;
    logic [ANG_W-1:0]          rem_sh;
    logic                      div_ge;
    logic signed [MUL_B_W-1:0] tanq;
    logic [47:0]               head_sum;
    logic [15:0]               hfold;
    logic                      hneg;
    logic signed [65:0]        pos_total;
    logic signed [27:0]        pos_d;
    logic signed [31:0]        pos_cur;
    logic signed [32:0]        pos_sum;
    logic                      pos_ovf;
    logic signed [31:0]        pos_new;
    logic signed [ANG_W-1:0]   c1_cos;
    logic signed [ANG_W-1:0]   c1_abs_s;

    bdr_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_val (cor_cos),
        .sin_val (cor_sin)
    );

    always_comb
    begin
        if (held_steer_reg > STEER_LIM)
        begin
            steer_cl = STEER_LIM;
        end
        else if (held_steer_reg < -STEER_LIM)
        begin
            steer_cl = -STEER_LIM;
        end
        else
        begin
            steer_cl = held_steer_reg;
        end

        cor_start = (state_reg == S_C1_GO) || (state_reg == S_C2_GO);
        if (state_reg == S_C1_GO)
        begin
            cor_angle = ANG_W'(steer_cl) <<< 17;
        end
        else
        begin
            cor_angle = prod_reg[48:15];
        end

        c1_cos   = (cor_cos <= 0) ? 34'sd1 : cor_cos;
        c1_abs_s = cor_sin[ANG_W-1] ? -cor_sin : cor_sin;

        rem_sh = {rem_reg[ANG_W-2:0], dq_reg[DIV_Q_W-1]};
        div_ge = rem_sh >= c_reg;
        tanq   = sneg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});

        head_sum = acc_reg[47:0] + {prod_reg[23:0], 24'd0} + 48'h0000_8000_0000;

        hneg  = ($signed(heading_reg) > 16'sd16384) || ($signed(heading_reg) < -16'sd16384);
        hfold = hneg ? {~heading_reg[15], heading_reg[14:0]} : heading_reg;

        pos_total = {{5{acc_reg[PROD_W-1]}}, acc_reg}
                  + ({{5{prod_reg[PROD_W-1]}}, prod_reg} <<< 24)
                  + (66'sd1 <<< 37);
        pos_d     = pos_total[65:38];
        pos_cur   = axis_reg ? z_reg : x_reg;
        pos_sum   = {pos_cur[31], pos_cur} + {{5{pos_d[27]}}, pos_d};
        pos_ovf   = pos_sum[32] != pos_sum[31];
        if (pos_ovf)
        begin
            pos_new = pos_sum[32] ? POS_MIN : POS_MAX;
        end
        else
        begin
            pos_new = pos_sum[31:0];
        end

        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            S_M1:
            begin
                mul_a = MUL_A_W'(tanq);
                mul_b = MUL_B_W'(held_speed_reg);
            end
            S_M2:
            begin
                mul_a = prod_reg[43:8];
                mul_b = $signed({3'd0, inv_wb_reg});
            end
            S_M3:
            begin
                mul_a = prod_reg[51:16];
                mul_b = $signed({9'd0, dt_reg});
            end
            S_M4A:
            begin
                mul_a = INV2PI_Q32;
                mul_b = $signed({1'b0, prod_reg[39:16]});
            end
            S_M4B:
            begin
                mul_a = INV2PI_Q32;
                mul_b = hold_reg;
            end
            S_ANG:
            begin
                mul_a = PI_Q30;
                mul_b = MUL_B_W'($signed(hfold));
            end
            S_M5:
            begin
                mul_a = MUL_A_W'(axis_reg ? s_reg : c_reg);
                mul_b = MUL_B_W'(held_speed_reg);
            end
            S_M6A:
            begin
                mul_a = $signed({20'd0, dt_reg});
                mul_b = $signed({1'b0, prod_reg[23:0]});
            end
            S_M6B:
            begin
                mul_a = $signed({20'd0, dt_reg});
                mul_b = hold_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            inv_wb_reg     <= 22'd51200;
            start_hd_reg   <= 16'd16384;
            x_reg          <= '0;
            z_reg          <= '0;
            heading_reg    <= 16'd16384;
            held_steer_reg <= '0;
            held_speed_reg <= '0;
            sat_reg        <= 1'b0;
            axis_reg       <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_INV_WHEELBASE)
                begin
                    inv_wb_reg <= cfg_wdata;
                end
                else
                begin
                    start_hd_reg <= cfg_wdata[15:0];
                end
            end

            if (mul_en)
            begin
                prod_reg <= mul_a * mul_b;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        sat_reg <= 1'b0;
                        dt_reg  <= time_step;
                        if (req_type == REQ_RESTART)
                        begin
                            x_reg          <= '0;
                            z_reg          <= '0;
                            heading_reg    <= start_hd_reg;
                            held_steer_reg <= '0;
                            held_speed_reg <= '0;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            if (sample_valid)
                            begin
                                held_steer_reg <= steer_angle;
                                held_speed_reg <= speed;
                            end
                            state_reg <= S_C1_GO;
                        end
                    end
                end
                S_C1_GO:
                begin
                    state_reg <= S_C1_WAIT;
                end
                S_C1_WAIT:
                begin
                    if (cor_done)
                    begin
                        c_reg       <= c1_cos;
                        sneg_reg    <= cor_sin[ANG_W-1];
                        rem_reg     <= ANG_W'(c1_abs_s[ANG_W-1:8]);
                        dq_reg      <= {c1_abs_s[7:0], 16'd0};
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg     <= div_ge ? rem_sh - c_reg : rem_sh;
                    dq_reg      <= {dq_reg[DIV_Q_W-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 5'(DIV_Q_W - 1))
                    begin
                        state_reg <= S_M1;
                    end
                end
                S_M1:
                begin
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    state_reg <= S_M4A;
                end
                S_M4A:
                begin
                    hold_reg  <= MUL_B_W'($signed(prod_reg[60:40]));
                    state_reg <= S_M4B;
                end
                S_M4B:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    heading_reg <= heading_reg - head_sum[47:32];
                    state_reg   <= S_ANG;
                end
                S_ANG:
                begin
                    neg_reg   <= hneg;
                    state_reg <= S_C2_GO;
                end
                S_C2_GO:
                begin
                    state_reg <= S_C2_WAIT;
                end
                S_C2_WAIT:
                begin
                    if (cor_done)
                    begin
                        c_reg     <= neg_reg ? -cor_cos : cor_cos;
                        s_reg     <= neg_reg ? -cor_sin : cor_sin;
                        axis_reg  <= 1'b0;
                        state_reg <= S_M5;
                    end
                end
                S_M5:
                begin
                    state_reg <= S_M6A;
                end
                S_M6A:
                begin
                    hold_reg  <= prod_reg[48:24];
                    state_reg <= S_M6B;
                end
                S_M6B:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    if (pos_ovf)
                    begin
                        sat_reg <= 1'b1;
                    end
                    if (axis_reg)
                    begin
                        z_reg     <= pos_new;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        x_reg     <= pos_new;
                        axis_reg  <= 1'b1;
                        state_reg <= S_M5;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready      = state_reg == S_IDLE;
    assign out_valid     = state_reg == S_OUT;
    assign pos_x         = x_reg;
    assign pos_z         = z_reg;
    assign heading_angle = heading_reg;
    assign saturated     = sat_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output sides active together");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type |=> out_valid && pos_x == 0 && pos_z == 0
            && !saturated)
        else $error("restart did not give a cleared pose");

    a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> pos_x == POS_MAX || pos_x == POS_MIN
            || pos_z == POS_MAX || pos_z == POS_MIN)
        else $error("saturation flag without a clipped position");

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Bicycle dead reckoning step testbench
// Drives restart and step items with random idling on both channels, keeps
// its own fixed-point model of the pose and checks every result in order.
// The configuration registers are changed between phases while idle.
// ----------------------------------------------------------------------------
module testbench;
    import bdr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    class pose_scoreboard;
        logic [21:0] inv_wb;
        logic [15:0] start_hdg;
        logic signed [31:0] x_pos;
        logic signed [31:0] z_pos;
        logic [15:0] hdg;
        logic signed [14:0] held_steer;
        logic signed [15:0] held_speed;
        logic [80:0] expected_q[$];
        int mismatches;

        function void reset_state();
            inv_wb = 22'd51200;
            start_hdg = 16'd16384;
            x_pos = 0;
            z_pos = 0;
            hdg = 16'd16384;
            held_steer = 0;
            held_speed = 0;
        endfunction

        function void write_reg(logic idx, logic [21:0] val);
            if (idx == REG_INV_WHEELBASE)
                inv_wb = val;
            else
                start_hdg = val[15:0];
        endfunction

        function longint atan_val(int i);
            longint tbl[10] = '{843314857, 497837829, 263043836, 133525158, 67021686,
                                33543515, 16771754, 8388437, 4194282, 2097149};
            if (i < 10)
                return tbl[i];
            return longint'(1) << (30 - i);
        endfunction

        function void rotate(longint ang, output longint c, output longint s);
            longint xv;
            longint yv;
            longint zv;
            longint dx;
            longint dy;
            xv = 652032874;
            yv = 0;
            zv = ang;
            for (int i = 0; i < 16; i++)
            begin
                dx = yv >>> i;
                dy = xv >>> i;
                if (zv >= 0)
                begin
                    xv -= dx;
                    yv += dy;
                    zv -= atan_val(i);
                end
                else
                begin
                    xv += dx;
                    yv -= dy;
                    zv += atan_val(i);
                end
            end
            c = xv;
            s = yv;
        endfunction

        function logic signed [31:0] sat_add(logic signed [31:0] p, longint d, ref bit f);
            longint n;
            n = longint'(p) + d;
            if (n > 64'sd2147483647)
            begin
                f = 1;
                return POS_MAX;
            end
            if (n < -64'sd2147483648)
            begin
                f = 1;
                return POS_MIN;
            end
            return n[31:0];
        endfunction

        function void note_item(logic rq, logic sv, logic signed [14:0] st,
                                logic signed [15:0] sp, logic [15:0] dt_in);
            longint steer;
            longint spd;
            longint dt;
            longint c;
            longint s;
            longint tanq;
            longint p;
            longint d;
            longint h;
            bit neg;
            bit sat;
            sat = 0;
            if (rq == REQ_RESTART)
            begin
                x_pos = 0;
                z_pos = 0;
                hdg = start_hdg;
                held_steer = 0;
                held_speed = 0;
            end
            else
            begin
                if (sv)
                begin
                    held_steer = st;
                    held_speed = sp;
                end
                dt = dt_in;
                spd = held_speed;
                steer = held_steer;
                if (steer > 12288)
                    steer = 12288;
                if (steer < -12288)
                    steer = -12288;
                rotate(steer * 131072, c, s);
                if (c <= 0)
                    c = 1;
                tanq = (s * 65536) / c;
                p = (tanq * spd) >>> 8;
                p = (p * longint'(inv_wb)) >>> 16;
                p = (p * dt) >>> 16;
                d = (p * 683565276 + (longint'(1) << 31)) >>> 32;
                hdg = hdg - d[15:0];
                h = longint'($signed(hdg));
                neg = 0;
                if (h > 16384)
                begin
                    h -= 32768;
                    neg = 1;
                end
                else if (h < -16384)
                begin
                    h += 32768;
                    neg = 1;
                end
                rotate((h * 64'sd3373259426) >>> 15, c, s);
                if (neg)
                begin
                    c = -c;
                    s = -s;
                end
                d = (c * spd * dt + (longint'(1) << 37)) >>> 38;
                x_pos = sat_add(x_pos, d, sat);
                d = (s * spd * dt + (longint'(1) << 37)) >>> 38;
                z_pos = sat_add(z_pos, d, sat);
            end
            expected_q.push_back({x_pos, z_pos, hdg, sat});
        endfunction

        function void check_result(logic [80:0] got);
            logic [80:0] want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result item %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: x %0d/%0d z %0d/%0d hdg %0d/%0d sat %0d/%0d",
                             $signed(want[80:49]), $signed(got[80:49]),
                             $signed(want[48:17]), $signed(got[48:17]),
                             want[16:1], got[16:1], want[0], got[0]);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 1;
    logic in_valid = 0;
    logic in_ready;
    logic req_type = 0;
    logic sample_valid = 0;
    logic signed [14:0] steer_angle = 0;
    logic signed [15:0] speed = 0;
    logic [15:0] time_step = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic [15:0] heading_angle;
    logic saturated;
    logic cfg_wr_en = 0;
    logic cfg_index = 0;
    logic [21:0] cfg_wdata = 0;

    pose_scoreboard sb = new();
    bit stim_done = 0;
    bit calm = 0;

    bicycle_dead_reckoning_step u_top (.*);

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_item(req_type, sample_valid, steer_angle, speed, time_step);
        if (out_valid && out_ready)
            sb.check_result({pos_x, pos_z, heading_angle, saturated});
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            out_ready <= 1;
        end
    end

    task automatic send_item(logic rq, logic sv, logic signed [14:0] st,
                             logic signed [15:0] sp, logic [15:0] dt);
        if (!calm && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4)) @(negedge clk);
        in_valid <= 1;
        req_type <= rq;
        sample_valid <= sv;
        steer_angle <= st;
        speed <= sp;
        time_step <= dt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid <= 0;
        @(negedge clk);
    endtask

    task automatic send_random();
        int r;
        logic signed [14:0] st;
        r = $urandom_range(0, 99);
        st = $urandom_range(0, 3) == 0 ? 15'($urandom) : 15'($signed($urandom_range(0, 24576)) - 12288);
        if (r < 3)
            send_item(REQ_RESTART, 1'($urandom), 15'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 60)
            send_item(REQ_STEP, 1, st, 16'($urandom), 16'($urandom));
        else if (r < 80)
            send_item(REQ_STEP, 1'($urandom), st, 16'($signed($urandom_range(0, 2560)) - 1280),
                      16'($urandom_range(0, 3300)));
        else
            send_item(REQ_STEP, 0, 15'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic write_cfg(logic idx, logic [21:0] val);
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 0;
        sb.write_reg(idx, val);
    endtask

    initial
    begin
        logic [21:0] wb_set[4] = '{22'd51200, 22'd0, 22'h3fffff, 22'd131072};
        logic [15:0] hd_set[4] = '{16'd16384, 16'd0, 16'hffff, 16'd32768};
        sb.reset_state();
        #1 rst_n = 0;
        repeat (11) @(negedge clk);
        rst_n = 1;
        send_item(REQ_STEP, 1, 0, 16'sd256, 16'hffff);
        send_item(REQ_STEP, 1, 15'sd12288, 16'sd32767, 16'hffff);
        send_item(REQ_STEP, 1, -15'sd12288, -16'sd32768, 16'hffff);
        send_item(REQ_STEP, 1, 15'sh3fff, 16'sd1000, 16'd1000);
        send_item(REQ_STEP, 1, 15'sh4000, 16'sd1000, 16'd1000);
        send_item(REQ_STEP, 0, 15'sd5, 16'sd7, 16'd0);
        send_item(REQ_STEP, 1, 15'sd100, 16'sd32767, 16'hffff);
        repeat (12) send_item(REQ_STEP, 0, 0, 0, 16'hffff);
        send_item(REQ_RESTART, 1, 15'sd77, 16'sd99, 16'd5);
        send_item(REQ_STEP, 0, 0, 0, 16'hffff);
        for (int ph = 0; ph < 8; ph++)
        begin
            write_cfg(REG_INV_WHEELBASE, wb_set[ph % 4]);
            write_cfg(REG_START_HEADING, hd_set[(ph + 1) % 4]);
            if (ph == 7)
                calm = 1;
            send_item(REQ_RESTART, 0, 0, 0, 0);
            repeat (215) send_random();
        end
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
